### rtl/core/profile_sample_hash_counter_macros.svh
// assertion macros used by the port checker
`ifndef PROFILE_SAMPLE_HASH_COUNTER_MACROS_SVH
`define PROFILE_SAMPLE_HASH_COUNTER_MACROS_SVH

// same-cycle implication, sampled on clk, off during reset
`define PSHC_ASSERT_NOW(label, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("pshc port check failed");

// next-cycle implication, sampled on clk, off during reset
`define PSHC_ASSERT_NEXT(label, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("pshc port check failed");

`endif

### rtl/core/pshc_pkg.sv
package pshc_pkg;

	localparam int BUCKETS     = 4096;
	localparam int WAYS        = 4;
	localparam int COUNT_BITS  = 14;
	localparam int BUCKET_BITS = $clog2(BUCKETS);
	localparam int WAY_BITS    = $clog2(WAYS);
	localparam int QUEUE_DEPTH = 2;

	localparam int PID_BITS     = 16;
	localparam int ADDR_BITS    = 32;
	localparam int CTR_BITS     = 2;
	localparam int SHIFT_BITS   = 5;
	localparam int CFG_IDX_BITS = 2;
	localparam int EVICT_BITS   = 32;

	localparam logic [COUNT_BITS-1:0] COUNT_MAX = '1;

	localparam logic [SHIFT_BITS-1:0] ADDR_RS_RESET = 5'd2;
	localparam logic [SHIFT_BITS-1:0] PID_LS_RESET  = 5'd0;
	localparam logic [SHIFT_BITS-1:0] ADDR_LS_RESET = 5'd10;
	localparam logic [SHIFT_BITS-1:0] CTR_LS_RESET  = 5'd8;

	typedef enum logic [CFG_IDX_BITS-1:0] {
		CFG_ADDR_RS = 2'd0,
		CFG_PID_LS  = 2'd1,
		CFG_ADDR_LS = 2'd2,
		CFG_CTR_LS  = 2'd3
	} cfg_idx_t;

	typedef enum logic [1:0] {
		OUT_HIT  = 2'd0,
		OUT_FILL = 2'd1,
		OUT_SAT  = 2'd2,
		OUT_RR   = 2'd3
	} outcome_t;

	typedef enum logic [1:0] {
		ST_CLEAR,
		ST_IDLE,
		ST_LOOK
	} back_state_t;

	// one way of a bucket; a count of zero marks the way empty
	typedef struct packed {
		logic [ADDR_BITS-1:0]  addr;
		logic [PID_BITS-1:0]   pid;
		logic [COUNT_BITS-1:0] count;
	} entry_t;

	typedef entry_t [WAYS-1:0] row_t;

	typedef struct packed {
		logic [BUCKET_BITS-1:0] bucket;
		logic [PID_BITS-1:0]    pid;
		logic [ADDR_BITS-1:0]   addr;
	} sample_t;

endpackage

### rtl/core/pshc_front.sv
module pshc_front (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                in_valid,
	output logic                                in_ready,
	input  logic [pshc_pkg::PID_BITS-1:0]       proc_id,
	input  logic [pshc_pkg::ADDR_BITS-1:0]      instr_addr,
	input  logic [pshc_pkg::CTR_BITS-1:0]       counter_num,
	input  logic                                cfg_valid,
	output logic                                cfg_ready,
	input  logic [pshc_pkg::CFG_IDX_BITS-1:0]   cfg_index,
	input  logic [pshc_pkg::SHIFT_BITS-1:0]     cfg_data,
	input  logic                                clearing,
	input  logic                                q_full,
	output logic                                push,
	output pshc_pkg::sample_t                   push_item
);

	logic [pshc_pkg::SHIFT_BITS-1:0] addr_rs_q;
	logic [pshc_pkg::SHIFT_BITS-1:0] pid_ls_q;
	logic [pshc_pkg::SHIFT_BITS-1:0] addr_ls_q;
	logic [pshc_pkg::SHIFT_BITS-1:0] ctr_ls_q;
	logic [pshc_pkg::ADDR_BITS-1:0]  hash;

	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			addr_rs_q <= pshc_pkg::ADDR_RS_RESET;
			pid_ls_q  <= pshc_pkg::PID_LS_RESET;
			addr_ls_q <= pshc_pkg::ADDR_LS_RESET;
			ctr_ls_q  <= pshc_pkg::CTR_LS_RESET;
		end else if (cfg_valid) begin
			case (pshc_pkg::cfg_idx_t'(cfg_index))
				pshc_pkg::CFG_ADDR_RS: addr_rs_q <= cfg_data;
				pshc_pkg::CFG_PID_LS:  pid_ls_q  <= cfg_data;
				pshc_pkg::CFG_ADDR_LS: addr_ls_q <= cfg_data;
				pshc_pkg::CFG_CTR_LS:  ctr_ls_q  <= cfg_data;
				default: ;
			endcase
		end
	end

	// xor of shifted fields, 32 bits wide
	always_comb begin
		hash = (instr_addr >> addr_rs_q)
			^ ({{(pshc_pkg::ADDR_BITS-pshc_pkg::PID_BITS){1'b0}}, proc_id} << pid_ls_q)
			^ (instr_addr << addr_ls_q)
			^ ({{(pshc_pkg::ADDR_BITS-pshc_pkg::CTR_BITS){1'b0}}, counter_num} << ctr_ls_q);
	end

	assign in_ready = !clearing && !q_full;
	assign push     = in_valid && in_ready;

	always_comb begin
		push_item.bucket = hash[pshc_pkg::BUCKET_BITS-1:0];
		push_item.pid    = proc_id;
		push_item.addr   = instr_addr;
	end

endmodule

### rtl/core/pshc_queue.sv
module pshc_queue (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              push,
	input  pshc_pkg::sample_t push_item,
	output logic              full,
	input  logic              pop,
	output logic              pop_valid,
	output pshc_pkg::sample_t pop_item
);

	localparam int PTR_BITS = $clog2(pshc_pkg::QUEUE_DEPTH);
	localparam int CNT_BITS = $clog2(pshc_pkg::QUEUE_DEPTH + 1);

	pshc_pkg::sample_t   slots_q [pshc_pkg::QUEUE_DEPTH];
	logic [PTR_BITS-1:0] wr_ptr_q;
	logic [PTR_BITS-1:0] rd_ptr_q;
	logic [CNT_BITS-1:0] cnt_q;

	assign full      = cnt_q == CNT_BITS'(pshc_pkg::QUEUE_DEPTH);
	assign pop_valid = cnt_q != '0;
	assign pop_item  = slots_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (push) begin
			slots_q[wr_ptr_q] <= push_item;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			cnt_q    <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= (wr_ptr_q == PTR_BITS'(pshc_pkg::QUEUE_DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
			end
			if (pop) begin
				rd_ptr_q <= (rd_ptr_q == PTR_BITS'(pshc_pkg::QUEUE_DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
			end
			if (push && !pop) begin
				cnt_q <= cnt_q + 1'b1;
			end else if (pop && !push) begin
				cnt_q <= cnt_q - 1'b1;
			end
		end
	end

endmodule

### rtl/core/pshc_back.sv
module pshc_back (
	input  logic                               clk,
	input  logic                               arst_n,
	output logic                               clearing,
	input  logic                               q_valid,
	input  pshc_pkg::sample_t                  q_item,
	output logic                               pop,
	output logic                               out_valid,
	input  logic                               out_ready,
	output logic [1:0]                         outcome,
	output logic [pshc_pkg::BUCKET_BITS-1:0]   bucket,
	output logic [pshc_pkg::WAY_BITS-1:0]      way,
	output logic [pshc_pkg::COUNT_BITS-1:0]    new_count,
	output logic [pshc_pkg::EVICT_BITS-1:0]    evictions
);

	pshc_pkg::row_t        mem [pshc_pkg::BUCKETS];
	pshc_pkg::row_t        rd_row_s1;
	pshc_pkg::sample_t     item_q;
	pshc_pkg::back_state_t state_q, state_d;

	logic [pshc_pkg::BUCKET_BITS-1:0] clr_idx_q;
	logic [pshc_pkg::WAY_BITS-1:0]    victim_q;
	logic [pshc_pkg::EVICT_BITS-1:0]  evict_q;
	logic                             out_valid_q;

	logic                             mem_re, mem_we, commit;
	logic [pshc_pkg::BUCKET_BITS-1:0] wr_addr;
	pshc_pkg::row_t                   wr_row, upd_row;

	logic [pshc_pkg::WAYS-1:0]        hit, sat, sel;
	logic [pshc_pkg::WAY_BITS-1:0]    pick;
	logic                             found, evict;
	pshc_pkg::outcome_t               res;
	logic [pshc_pkg::COUNT_BITS-1:0]  cnt_new;

	// next state
	always_comb begin
		state_d = state_q;
		case (state_q)
			pshc_pkg::ST_CLEAR: begin
				if (clr_idx_q == pshc_pkg::BUCKET_BITS'(pshc_pkg::BUCKETS - 1)) begin
					state_d = pshc_pkg::ST_IDLE;
				end
			end
			pshc_pkg::ST_IDLE: begin
				if (q_valid) begin
					state_d = pshc_pkg::ST_LOOK;
				end
			end
			pshc_pkg::ST_LOOK: begin
				if (!out_valid_q || out_ready) begin
					state_d = pshc_pkg::ST_IDLE;
				end
			end
			default: state_d = pshc_pkg::ST_CLEAR;
		endcase
	end

	// control outputs
	always_comb begin
		clearing = 1'b0;
		pop      = 1'b0;
		mem_re   = 1'b0;
		mem_we   = 1'b0;
		commit   = 1'b0;
		wr_addr  = item_q.bucket;
		wr_row   = upd_row;
		case (state_q)
			pshc_pkg::ST_CLEAR: begin
				clearing = 1'b1;
				mem_we   = 1'b1;
				wr_addr  = clr_idx_q;
				wr_row   = '0;
			end
			pshc_pkg::ST_IDLE: begin
				pop    = q_valid;
				mem_re = q_valid;
			end
			pshc_pkg::ST_LOOK: begin
				commit = !out_valid_q || out_ready;
				mem_we = commit;
			end
			default: clearing = 1'b1;
		endcase
	end

	// way selection: first way that hits, is saturated, or is empty
	always_comb begin
		hit   = '0;
		sat   = '0;
		sel   = '0;
		pick  = victim_q;
		found = 1'b0;
		for (int i = 0; i < pshc_pkg::WAYS; i++) begin
			sat[i] = rd_row_s1[i].count == pshc_pkg::COUNT_MAX;
			hit[i] = (rd_row_s1[i].count != '0) && !sat[i]
				&& (rd_row_s1[i].addr == item_q.addr) && (rd_row_s1[i].pid == item_q.pid);
			sel[i] = hit[i] || sat[i] || (rd_row_s1[i].count == '0);
		end
		for (int i = pshc_pkg::WAYS - 1; i >= 0; i--) begin
			if (sel[i]) begin
				pick  = pshc_pkg::WAY_BITS'(i);
				found = 1'b1;
			end
		end
		if (!found) begin
			res = pshc_pkg::OUT_RR;
		end else if (hit[pick]) begin
			res = pshc_pkg::OUT_HIT;
		end else if (sat[pick]) begin
			res = pshc_pkg::OUT_SAT;
		end else begin
			res = pshc_pkg::OUT_FILL;
		end
		evict   = (res == pshc_pkg::OUT_SAT) || (res == pshc_pkg::OUT_RR);
		cnt_new = (res == pshc_pkg::OUT_HIT) ? rd_row_s1[pick].count + 1'b1
			: pshc_pkg::COUNT_BITS'(1);
		upd_row = rd_row_s1;
		upd_row[pick].addr  = item_q.addr;
		upd_row[pick].pid   = item_q.pid;
		upd_row[pick].count = cnt_new;
	end

	// table memory, registered read
	always_ff @(posedge clk) begin
		if (mem_we) begin
			mem[wr_addr] <= wr_row;
		end
		if (mem_re) begin
			rd_row_s1 <= mem[q_item.bucket];
		end
	end

	always_ff @(posedge clk) begin
		if (pop) begin
			item_q <= q_item;
		end
		if (commit) begin
			outcome   <= res;
			bucket    <= item_q.bucket;
			way       <= pick;
			new_count <= cnt_new;
			evictions <= evict ? evict_q + 1'b1 : evict_q;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= pshc_pkg::ST_CLEAR;
			clr_idx_q   <= '0;
			victim_q    <= '0;
			evict_q     <= '0;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (state_q == pshc_pkg::ST_CLEAR) begin
				clr_idx_q <= clr_idx_q + 1'b1;
			end
			if (commit) begin
				out_valid_q <= 1'b1;
				if (evict) begin
					evict_q <= evict_q + 1'b1;
				end
				if (res == pshc_pkg::OUT_RR) begin
					victim_q <= (victim_q == pshc_pkg::WAY_BITS'(pshc_pkg::WAYS - 1)) ? '0
						: victim_q + 1'b1;
				end
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	assign out_valid = out_valid_q;

endmodule

### rtl/core/profile_sample_hash_counter.sv
// profile sample hash counter: counts profiling samples in a 4096-bucket, 4-way table keyed
// by instruction address and process id. each sample is hashed to a bucket by an xor of
// shifted fields (shift amounts in four config registers, written on the cfg channel, which
// is always ready). the first way of the bucket that matches with headroom, is saturated, or
// is empty gets the sample; if none does, a shared round-robin pointer picks the victim.
// one result per sample, in order. after reset the table is cleared one bucket per cycle,
// and in_ready stays low until that pass is done. samples are hashed combinationally and
// taken into a two-entry queue; the back end first reads the bucket row from the table
// memory, then decides, writes the row back and loads the result register, and it takes
// no new sample until that read-modify-write on the single table memory is done. a result
// waiting on out_ready holds the back end, while the queue keeps taking samples until it
// is full.
module profile_sample_hash_counter (
	input  logic                               clk,
	input  logic                               arst_n,
	// sample channel
	input  logic                               in_valid,
	output logic                               in_ready,
	input  logic [pshc_pkg::PID_BITS-1:0]      proc_id,
	input  logic [pshc_pkg::ADDR_BITS-1:0]     instr_addr,
	input  logic [pshc_pkg::CTR_BITS-1:0]      counter_num,
	// result channel
	output logic                               out_valid,
	input  logic                               out_ready,
	output logic [1:0]                         outcome,
	output logic [pshc_pkg::BUCKET_BITS-1:0]   bucket,
	output logic [pshc_pkg::WAY_BITS-1:0]      way,
	output logic [pshc_pkg::COUNT_BITS-1:0]    new_count,
	output logic [pshc_pkg::EVICT_BITS-1:0]    evictions,
	// config write channel
	input  logic                               cfg_valid,
	output logic                               cfg_ready,
	input  logic [pshc_pkg::CFG_IDX_BITS-1:0]  cfg_index,
	input  logic [pshc_pkg::SHIFT_BITS-1:0]    cfg_data
);

	// front to queue
	logic              push;
	pshc_pkg::sample_t push_item;
	logic              q_full;
	// queue to back
	logic              q_valid;
	logic              pop;
	pshc_pkg::sample_t q_item;
	// back is sweeping the table after reset
	logic              clearing;

	// hashing and acceptance of sample transactions, config registers
	pshc_front u_front (
		.clk         (clk),
		.arst_n      (arst_n),
		.in_valid    (in_valid),
		.in_ready    (in_ready),
		.proc_id     (proc_id),
		.instr_addr  (instr_addr),
		.counter_num (counter_num),
		.cfg_valid   (cfg_valid),
		.cfg_ready   (cfg_ready),
		.cfg_index   (cfg_index),
		.cfg_data    (cfg_data),
		.clearing    (clearing),
		.q_full      (q_full),
		.push        (push),
		.push_item   (push_item)
	);

	// decouples hashing from the table update
	pshc_queue u_queue (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (push),
		.push_item (push_item),
		.full      (q_full),
		.pop       (pop),
		.pop_valid (q_valid),
		.pop_item  (q_item)
	);

	// table memory, way choice, eviction count and result register
	pshc_back u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.clearing  (clearing),
		.q_valid   (q_valid),
		.q_item    (q_item),
		.pop       (pop),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.outcome   (outcome),
		.bucket    (bucket),
		.way       (way),
		.new_count (new_count),
		.evictions (evictions)
	);

endmodule

### rtl/core/pshc_port_checker.sv
`include "profile_sample_hash_counter_macros.svh"

module pshc_port_checker (
	input  logic                               clk,
	input  logic                               arst_n,
	input  logic                               in_valid,
	input  logic                               in_ready,
	input  logic [pshc_pkg::PID_BITS-1:0]      proc_id,
	input  logic [pshc_pkg::ADDR_BITS-1:0]     instr_addr,
	input  logic [pshc_pkg::CTR_BITS-1:0]      counter_num,
	input  logic                               out_valid,
	input  logic                               out_ready,
	input  logic [1:0]                         outcome,
	input  logic [pshc_pkg::BUCKET_BITS-1:0]   bucket,
	input  logic [pshc_pkg::WAY_BITS-1:0]      way,
	input  logic [pshc_pkg::COUNT_BITS-1:0]    new_count,
	input  logic [pshc_pkg::EVICT_BITS-1:0]    evictions,
	input  logic                               cfg_valid,
	input  logic                               cfg_ready,
	input  logic [pshc_pkg::CFG_IDX_BITS-1:0]  cfg_index,
	input  logic [pshc_pkg::SHIFT_BITS-1:0]    cfg_data
);

	// a stalled result transaction keeps its valid and its eviction total
	`PSHC_ASSERT_NEXT(a_out_hold, out_valid && !out_ready, out_valid && $stable(evictions))

	// a hit increments a way that already held at least one sample
	`PSHC_ASSERT_NOW(a_hit_count, out_valid && (outcome == pshc_pkg::OUT_HIT), new_count > 1)

	// a fill or a replacement starts the way at one
	`PSHC_ASSERT_NOW(a_load_count, out_valid && (outcome != pshc_pkg::OUT_HIT), new_count == 1)

	// the other result fields hold too while a result is stalled, even across new samples
	`PSHC_ASSERT_NEXT(a_out_stable, out_valid && !out_ready,
		$stable(outcome) && $stable(bucket) && $stable(way) && $stable(new_count))

endmodule

bind profile_sample_hash_counter pshc_port_checker u_pshc_port_checker (.*);
